### sv/fabd_pkg.sv
// Shared types, constants and helper functions of the face anchor box decoder.
// No dependencies; imported by every module of the block.
package fabd_pkg;

  localparam int NUM_LEVELS       = 3;
  localparam int ANCHORS_PER_CELL = 2;
  localparam int NUM_LANDMARKS    = 5;
  localparam int MAX_INPUT_SIDE   = 1024;

  localparam int ANCHOR_W = (ANCHORS_PER_CELL > 1) ? $clog2(ANCHORS_PER_CELL) : 1;
  localparam int LM_W     = $clog2(NUM_LANDMARKS + 1);

  localparam int LEVEL_W  = 2;
  localparam int INDEX_W  = 8;
  localparam int SHIFT_W  = 3;
  localparam int SIDE_W   = 11;
  localparam int FRAME_W  = 14;
  localparam int SCORE_W  = 16;
  localparam int SCALE_W  = 24;
  localparam int OFFSET_W = 16;
  localparam int COORD_W  = 25;
  localparam int Q8_W     = 23;   // centre +/- offset*stride, Q.8 input pixels
  localparam int PROD_W   = 48;   // Q8_W signed times unsigned scale

  // item kind codes, input and result
  localparam logic KIND_HEAD     = 1'b0;
  localparam logic KIND_LANDMARK = 1'b1;

  // log2 of the stride of each level (8, 16, 32)
  localparam logic [SHIFT_W-1:0] LEVEL_SHIFT [3] = '{3'd3, 3'd4, 3'd5};

  localparam logic signed [33:0] COORD_MAX = 34'sd16777215;
  localparam logic signed [33:0] COORD_MIN = -34'sd16777216;

  typedef struct packed {
    logic [SIDE_W-1:0]  input_width;
    logic [SIDE_W-1:0]  input_height;
    logic [SCORE_W-1:0] score_threshold;
  } cfg_t;

  // walker view of the current item
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [SHIFT_W-1:0] shift;
    logic [INDEX_W-1:0] col;
    logic [INDEX_W-1:0] row;
  } walk_t;

  function automatic logic [SHIFT_W-1:0] level_shift(input logic [LEVEL_W-1:0] level);
    if (32'(level) < NUM_LEVELS) begin
      return LEVEL_SHIFT[level];
    end
    return LEVEL_SHIFT[0];
  endfunction

  // feature grid dimension: min(side, MAX_INPUT_SIDE) >> shift, at least 1
  function automatic logic [INDEX_W:0] feat_dim(input logic [SIDE_W-1:0] side,
                                                input logic [SHIFT_W-1:0] shift);
    logic [SIDE_W:0] s;
    logic [SIDE_W:0] d;
    s = ({1'b0, side} > (SIDE_W+1)'(MAX_INPUT_SIDE)) ? (SIDE_W+1)'(MAX_INPUT_SIDE)
                                                     : {1'b0, side};
    d = s >> shift;
    return (d == '0) ? (INDEX_W+1)'(1) : d[INDEX_W:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [33:0] v);
    if (v > COORD_MAX) begin
      return COORD_MAX[COORD_W-1:0];
    end
    if (v < COORD_MIN) begin
      return COORD_MIN[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

### sv/face_anchor_box_decoder.sv
// Face anchor box decoder top level: config registers, pipeline control,
// box clamp stage and output register. Depends on fabd_pkg, fabd_walker, fabd_scaler.
//
// Usage:
//  - s_* channel carries head items (tuser = 0: score and four distances) and
//    landmark items (tuser = 1: dx, dy). Per anchor: one head item, then five
//    landmark items, in level / row / column / anchor order.
//  - m_* channel carries results: a box (tuser = 0) for every anchor whose
//    score is at or above the threshold, then its five landmarks (tuser = 1),
//    tlast set on the fifth. Dropped anchors and items of the wrong kind give
//    nothing.
//  - cfg_* is a plain write port; write only while the block is idle.
//  - Path: an accepted item passes in turn through the operand, product,
//    rounding and clamp/output registers before its result is valid at the output.
//  - Throughput: while m_tready stays high, one item per cycle; each coordinate
//    lane has one multiplier; unstalled, every stage takes a new item each cycle.
//  - Stall: each stage holds while its successor is full, so bubbles close up;
//    s_tready falls only when all four stages hold results and m_tready is low.
//  - Reset: rst clears the anchor position, the pipeline and loads the
//    register defaults (640x640 input, 1920x1080 frame, threshold 0.5, scale 3).
module face_anchor_box_decoder (
  input  logic         clk,
  input  logic         rst,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // score, offset_a, offset_b, offset_c, offset_d
  input  logic         s_tuser,   // kind
  // result items
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // confidence, coord_x, coord_y, box_width, box_height
  output logic         m_tuser,   // result_kind
  output logic         m_tlast,   // last
  // configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import fabd_pkg::*;

  localparam logic [2:0] CFG_INPUT_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_INPUT_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_FRAME_WIDTH     = 3'd2;
  localparam logic [2:0] CFG_FRAME_HEIGHT    = 3'd3;
  localparam logic [2:0] CFG_SCORE_THRESHOLD = 3'd4;
  localparam logic [2:0] CFG_INVERSE_SCALE   = 3'd5;

  typedef struct packed {
    logic               kind;
    logic               last;
    logic [SCORE_W-1:0] score;
  } meta_t;

  // configuration registers
  logic [SIDE_W-1:0]  input_width;
  logic [SIDE_W-1:0]  input_height;
  logic [FRAME_W-1:0] frame_width;
  logic [FRAME_W-1:0] frame_height;
  logic [SCORE_W-1:0] score_threshold;
  logic [SCALE_W-1:0] inverse_scale;
  cfg_t               cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_width     <= SIDE_W'(640);
      input_height    <= SIDE_W'(640);
      frame_width     <= FRAME_W'(1920);
      frame_height    <= FRAME_W'(1080);
      score_threshold <= SCORE_W'(32768);
      inverse_scale   <= SCALE_W'(196608);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_WIDTH:     input_width     <= cfg_data[SIDE_W-1:0];
        CFG_INPUT_HEIGHT:    input_height    <= cfg_data[SIDE_W-1:0];
        CFG_FRAME_WIDTH:     frame_width     <= cfg_data[FRAME_W-1:0];
        CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[FRAME_W-1:0];
        CFG_SCORE_THRESHOLD: score_threshold <= cfg_data[SCORE_W-1:0];
        CFG_INVERSE_SCALE:   inverse_scale   <= cfg_data[SCALE_W-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  assign cfg.input_width     = input_width;
  assign cfg.input_height    = input_height;
  assign cfg.score_threshold = score_threshold;

  // input unpack
  logic [SCORE_W-1:0]         in_score;
  logic signed [OFFSET_W-1:0] off_a, off_b, off_c, off_d;
  assign in_score = s_tdata[15:0];
  assign off_a    = $signed(s_tdata[31:16]);
  assign off_b    = $signed(s_tdata[47:32]);
  assign off_c    = $signed(s_tdata[63:48]);
  assign off_d    = $signed(s_tdata[79:64]);

  // pipeline control: a stage loads when empty or its successor moves
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  assign rdy4     = !m_tvalid || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign accept   = s_tvalid && rdy1;

  walk_t walk;

  fabd_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (s_tuser),
    .score  (in_score),
    .cfg    (cfg),
    .walk   (walk)
  );

  // anchor centre and stride-scaled offsets, Q.8 input pixels
  logic signed [Q8_W-1:0] cx, cy;
  logic signed [Q8_W-1:0] sa, sb, sc, sd;
  logic [3:0]             cshift;

  assign cshift = {1'b0, walk.shift} + 4'd8;
  assign cx     = Q8_W'(walk.col) << cshift;
  assign cy     = Q8_W'(walk.row) << cshift;
  assign sa     = Q8_W'(off_a) <<< walk.shift;
  assign sb     = Q8_W'(off_b) <<< walk.shift;
  assign sc     = Q8_W'(off_c) <<< walk.shift;
  assign sd     = Q8_W'(off_d) <<< walk.shift;

  // stage 1: operands
  meta_t                  m1, m2, m3;
  logic signed [Q8_W-1:0] qa1, qb1, qc1, qd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= accept && walk.emit;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      m1.kind  <= s_tuser;
      m1.last  <= walk.last;
      m1.score <= in_score;
      // box edges go left/up of the centre; landmarks add their offset
      qa1 <= (s_tuser == KIND_LANDMARK) ? cx + sa : cx - sa;
      qb1 <= (s_tuser == KIND_LANDMARK) ? cy + sb : cy - sb;
      qc1 <= cx + sc;
      qd1 <= cy + sd;
    end
    if (rdy2) m2 <= m1;
    if (rdy3) m3 <= m2;
  end

  // stages 2 and 3: scale and round, one lane per coordinate
  logic signed [COORD_W-1:0] ca, cb, cc, cd;

  fabd_scaler u_scale_a (.clk(clk), .en_prod(rdy2), .en_coord(rdy3), .q8(qa1),
                         .inv_scale(inverse_scale), .coord(ca));
  fabd_scaler u_scale_b (.clk(clk), .en_prod(rdy2), .en_coord(rdy3), .q8(qb1),
                         .inv_scale(inverse_scale), .coord(cb));
  fabd_scaler u_scale_c (.clk(clk), .en_prod(rdy2), .en_coord(rdy3), .q8(qc1),
                         .inv_scale(inverse_scale), .coord(cc));
  fabd_scaler u_scale_d (.clk(clk), .en_prod(rdy2), .en_coord(rdy3), .q8(qd1),
                         .inv_scale(inverse_scale), .coord(cd));

  // stage 4: clamp to frame, width/height, output register
  logic signed [FRAME_W:0]   fw_m1, fh_m1;
  logic signed [COORD_W-1:0] x_right, y_bottom;
  logic signed [COORD_W-1:0] x1, y1, x2, y2;
  logic signed [COORD_W-1:0] bw, bh;

  // a zero frame extent gives a bound of minus one pixel
  assign fw_m1    = $signed({1'b0, frame_width}) - (FRAME_W+1)'(1);
  assign fh_m1    = $signed({1'b0, frame_height}) - (FRAME_W+1)'(1);
  assign x_right  = {{(COORD_W-FRAME_W-9){fw_m1[FRAME_W]}}, fw_m1, 8'b0};
  assign y_bottom = {{(COORD_W-FRAME_W-9){fh_m1[FRAME_W]}}, fh_m1, 8'b0};
  assign x1       = ca[COORD_W-1] ? '0 : ca;
  assign y1       = cb[COORD_W-1] ? '0 : cb;
  assign x2       = (cc > x_right) ? x_right : cc;
  assign y2       = (cd > y_bottom) ? y_bottom : cd;
  assign bw       = sat_coord(34'(x2) - 34'(x1));
  assign bh       = sat_coord(34'(y2) - 34'(y1));

  logic [SCORE_W-1:0]        out_conf;
  logic signed [COORD_W-1:0] out_x, out_y, out_w, out_h;
  logic                      out_kind;
  logic                      out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy4) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_kind <= m3.kind;
      out_last <= m3.last;
      if (m3.kind == KIND_LANDMARK) begin
        out_conf <= '0;
        out_x    <= ca;
        out_y    <= cb;
        out_w    <= '0;
        out_h    <= '0;
      end else begin
        out_conf <= m3.score;
        out_x    <= x1;
        out_y    <= y1;
        out_w    <= bw;
        out_h    <= bh;
      end
    end
  end

  assign m_tdata = {4'b0, out_h, out_w, out_y, out_x, out_conf};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  // a box never closes a run
  a_box_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_HEAD) |-> !m_tlast)
    else $error("box result carries tlast");

  // box corner is clamped at zero
  a_box_origin: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_HEAD) |-> (!out_x[COORD_W-1] && !out_y[COORD_W-1]))
    else $error("box corner negative");

  // landmark results carry no score and no extent
  a_lm_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_LANDMARK) |-> (out_conf == '0 && out_w == '0 && out_h == '0))
    else $error("landmark result has box fields");

  // input stalls only when the whole pipeline is full and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && m_tvalid && !m_tready))
    else $error("input stalled with room in pipeline");
`endif

endmodule

### sv/fabd_walker.sv
// Anchor walker: tracks level, grid position, anchor and landmark slot.
// Decides per item whether a result is emitted. Depends on fabd_pkg.
module fabd_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        kind,
  input  logic [fabd_pkg::SCORE_W-1:0] score,
  input  fabd_pkg::cfg_t              cfg,
  output fabd_pkg::walk_t             walk
);
  import fabd_pkg::*;

  logic [LEVEL_W-1:0]  level;
  logic [INDEX_W-1:0]  row;
  logic [INDEX_W-1:0]  col;
  logic [ANCHOR_W-1:0] anchor;
  logic [LM_W-1:0]     lm;
  logic                kept;

  logic                expect_head;
  logic                keep_now;
  logic                final_one;
  logic                matched;
  logic [SHIFT_W-1:0]  shift;
  logic [ANCHOR_W:0]   anchor_inc;
  logic                anchor_wrap;
  logic [INDEX_W:0]    col_inc;
  logic                col_wrap;
  logic [INDEX_W:0]    row_inc;
  logic                row_wrap;
  logic [LEVEL_W:0]    level_inc;
  logic [ANCHOR_W-1:0] anchor_next;
  logic [INDEX_W-1:0]  col_next;
  logic [INDEX_W-1:0]  row_next;
  logic [LEVEL_W-1:0]  level_next;

  always_comb begin
    expect_head = (lm == '0);
    keep_now    = (score >= cfg.score_threshold);
    final_one   = (lm >= LM_W'(NUM_LANDMARKS));
    matched     = expect_head ? (kind == KIND_HEAD) : (kind == KIND_LANDMARK);
    shift       = level_shift(level);

    // position advance after the final landmark
    anchor_inc  = {1'b0, anchor} + 1'b1;
    anchor_wrap = (anchor_inc >= (ANCHOR_W+1)'(ANCHORS_PER_CELL));
    anchor_next = anchor_wrap ? '0 : anchor_inc[ANCHOR_W-1:0];
    col_inc     = {1'b0, col} + (INDEX_W+1)'(anchor_wrap);
    col_wrap    = (col_inc >= feat_dim(cfg.input_width, shift));
    col_next    = col_wrap ? '0 : col_inc[INDEX_W-1:0];
    row_inc     = {1'b0, row} + (INDEX_W+1)'(col_wrap);
    row_wrap    = (row_inc >= feat_dim(cfg.input_height, shift));
    row_next    = row_wrap ? '0 : row_inc[INDEX_W-1:0];
    level_inc   = {1'b0, level} + (LEVEL_W+1)'(row_wrap);
    level_next  = (level_inc >= (LEVEL_W+1)'(NUM_LEVELS)) ? '0 : level_inc[LEVEL_W-1:0];

    walk.emit   = matched && (expect_head ? keep_now : kept);
    walk.last   = !expect_head && final_one;
    walk.shift  = shift;
    walk.col    = col;
    walk.row    = row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      row    <= '0;
      col    <= '0;
      anchor <= '0;
      lm     <= '0;
      kept   <= 1'b0;
    end else if (accept && matched) begin
      if (expect_head) begin
        kept <= keep_now;
        lm   <= LM_W'(1);
      end else if (final_one) begin
        kept   <= 1'b0;
        lm     <= '0;
        anchor <= anchor_next;
        col    <= col_next;
        row    <= row_next;
        level  <= level_next;
      end else begin
        lm <= lm + 1'b1;
      end
    end
  end

endmodule

### sv/fabd_scaler.sv
// One coordinate lane: multiply by the inverse scale, then round half up
// to Q.8 and saturate to 25 bits. Two register stages. Depends on fabd_pkg.
module fabd_scaler (
  input  logic                              clk,
  input  logic                              en_prod,
  input  logic                              en_coord,
  input  logic signed [fabd_pkg::Q8_W-1:0]  q8,
  input  logic [fabd_pkg::SCALE_W-1:0]      inv_scale,
  output logic signed [fabd_pkg::COORD_W-1:0] coord
);
  import fabd_pkg::*;

  logic signed [SCALE_W:0]    scale_s;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   rounded;
  logic signed [PROD_W-17:0]  shifted;

  assign scale_s = $signed({1'b0, inv_scale});
  assign rounded = prod + PROD_W'(32768);
  assign shifted = rounded[PROD_W-1:16];   // floor divide by 2^16

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod <= PROD_W'(q8) * PROD_W'(scale_s);
    end
    if (en_coord) begin
      coord <= sat_coord(34'(shifted));
    end
  end

endmodule
